[rtl/b32e_pkg.sv]
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol lookup of the LSB-first base32
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b32e_pkg;

  // Bit counts of the encoding.
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned GROUP_BITS = 5;
  localparam int unsigned PEND_BITS  = 4;
  localparam int unsigned ACC_BITS   = PEND_BITS + BYTE_BITS;
  localparam int unsigned CHAR_BITS  = 7;
  localparam logic [4:0]  SYM_MASK   = 5'd31;

  // Depth of the job queue between front and back.
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_BITS  = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS  = $clog2(QDEPTH + 1);

  // Lower-case alphabet; the first character sits in the top byte.
  localparam logic [32*8-1:0] ALPHA_STR = "0123456789abcdefghjkmnpqrstvwxyz";

  // One classified item: merged bits, symbol count and closing flag.
  typedef struct packed {
    logic [ACC_BITS-1:0] acc;
    logic [1:0]          nsym;
    logic                fin;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // ASCII code of one 5-bit group.
  function automatic logic [CHAR_BITS-1:0] sym_char(input logic [4:0] idx);
    logic [4:0] pos;
    pos = SYM_MASK - idx;
    return ALPHA_STR[{pos, 3'b000} +: CHAR_BITS];
  endfunction

endpackage

`default_nettype wire

[rtl/b32e_chan_if.sv]
// ----------------------------------------------------------------------------
// b32e_chan_if
// Valid/ready channels of the encoder: byte items in, symbol items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b32e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface b32e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol_char;
  logic       last_symbol;

  modport source (output valid, symbol_char, last_symbol, input ready);
  modport sink   (input valid, symbol_char, last_symbol, output ready);
endinterface

`default_nettype wire

[rtl/b32e_front.sv]
// ----------------------------------------------------------------------------
// b32e_front
// Accepts byte items, merges each byte above the leftover bits and turns it
// into a job for the symbol generator.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  b32e_in_if.sink               in_ch,
  input  wire b32e_pkg::q_status_t q_stat,
  output      logic             push,
  output      b32e_pkg::job_t   push_job
);
  import b32e_pkg::*;

  logic [PEND_BITS-1:0] pend_bits_r, pend_bits_nxt;
  logic [2:0]           pend_cnt_r,  pend_cnt_nxt;
  logic [ACC_BITS-1:0]  acc;
  logic                 two_groups;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  // Place the new byte above the leftover bits and count the full groups.
  always_comb begin
    acc        = ACC_BITS'(pend_bits_r) | (ACC_BITS'(in_ch.data_byte) << pend_cnt_r);
    two_groups = (pend_cnt_r >= 3'd2);
    push_job.acc  = acc;
    push_job.fin  = in_ch.final_byte;
    push_job.nsym = (two_groups ? 2'd2 : 2'd1) + 2'(in_ch.final_byte);
  end

  // Leftover bits after the full groups; a closing symbol clears them.
  always_comb begin
    if (in_ch.final_byte) begin
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
    end else if (two_groups) begin
      pend_bits_nxt = {2'b00, acc[11:10]};
      pend_cnt_nxt  = pend_cnt_r - 3'd2;
    end else begin
      pend_bits_nxt = acc[8:5];
      pend_cnt_nxt  = pend_cnt_r + 3'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (push) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/b32e_queue.sv]
// ----------------------------------------------------------------------------
// b32e_queue
// Small job queue that decouples the front from the symbol generator.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire b32e_pkg::job_t      push_job,
  input  wire logic                pop,
  output      b32e_pkg::job_t      head_job,
  output      b32e_pkg::q_status_t q_stat
);
  import b32e_pkg::*;

  job_t                 slots_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic                 do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_BITS'(QDEPTH));
  assign q_stat.valid = (cnt_r != '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && q_stat.valid;
  assign head_job     = slots_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/b32e_back.sv]
// ----------------------------------------------------------------------------
// b32e_back
// Symbol generator: takes jobs from the queue and sends one symbol item per
// cycle, while the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b32e_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire b32e_pkg::job_t      head_job,
  input  wire b32e_pkg::q_status_t q_stat,
  output      logic                pop,
  b32e_out_if.source               out_ch
);
  import b32e_pkg::*;

  logic                 cur_valid_r;
  logic [ACC_BITS-1:0]  cur_acc_r;
  logic [1:0]           cur_cnt_r;
  logic                 cur_fin_r;
  logic                 out_valid_r;
  logic [CHAR_BITS-1:0] out_char_r;
  logic                 out_last_r;
  logic                 out_free, emit, cur_done;

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = cur_valid_r && out_free;
  assign cur_done = emit && (cur_cnt_r == 2'd1);
  assign pop      = q_stat.valid && (!cur_valid_r || cur_done);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol_char = out_char_r;
  assign out_ch.last_symbol = out_last_r;

  // Current job: load from the queue, or shift out one group per symbol.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
    end else if (cur_done) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_acc_r <= head_job.acc;
      cur_cnt_r <= head_job.nsym;
      cur_fin_r <= head_job.fin;
    end else if (emit) begin
      cur_acc_r <= cur_acc_r >> GROUP_BITS;
      cur_cnt_r <= cur_cnt_r - 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= sym_char(cur_acc_r[4:0]);
      out_last_r <= cur_fin_r && (cur_cnt_r == 2'd1);
    end
  end

endmodule

`default_nettype wire

[rtl/base32_lsb_first_encoder.sv]
// Path: an accepted item passes the job queue, the current-job register and
// the output register. The symbol generator sends one symbol per cycle while the
// receiver is ready; an item has one to three symbols (1.6 avg, plus a closing one).
// A four-entry job queue lets byte items be taken while symbols wait.
// Reset (synchronous, active low) clears leftover bits, queue and output valid.
// ----------------------------------------------------------------------------
// base32_lsb_first_encoder
// Encodes bytes, fed from the array's end, into lower-case base32 symbols,
// least significant group first, with a closing padded symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module base32_lsb_first_encoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  b32e_in_if.sink    in_ch,
  b32e_out_if.source out_ch
);
  import b32e_pkg::*;

  logic      push, pop;
  job_t      push_job, head_job;
  q_status_t q_stat;

  // Front: merge and classify.
  b32e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Job queue.
  b32e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // Back: symbol generation.
  b32e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[test/tb_base32_lsb_first_encoder.sv]
// ----------------------------------------------------------------------------
// tb_base32_lsb_first_encoder
// Self-checking bench for the LSB-first base32 encoder. A directed table walks
// the byte extremes and every leftover-bit count, including closings with no
// bits left and items that produce three symbols. Random arrays of mostly short
// and some long lengths follow. Every accepted byte is run through a local
// symbol predictor, and each symbol item from the block is checked against the
// oldest expected symbol. The sender idles in bursts and the receiver stalls
// on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_base32_lsb_first_encoder;

  // One predicted symbol item.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } sym_t;

  // One directed row; nexp > 0 means the symbols are typed in right here.
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [1:0]  nexp;
    logic [23:0] chars;
  } stim_row_t;

  localparam int NUM_ITEMS  = 480;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 8;

  // The clock starts low without a falling edge at time zero.
  logic clk = 1'b0;
  logic rst_n;

  b32e_in_if  in_ch ();
  b32e_out_if out_ch ();

  base32_lsb_first_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  string b32_alphabet = "0123456789abcdefghjkmnpqrstvwxyz";

  // Predictor state: leftover bits of the array in progress.
  logic [3:0] left_bits;
  logic [2:0] left_count;

  sym_t symbols_due[$];
  sym_t due_sym;
  int   errors      = 0;
  int   bytes_fed;
  int   burst_left;
  int   idle_cycles = 0;
  int   ready_mode  = 0;
  int   ready_phase = 0;
  int   stall_run   = 0;

  // Directed table: extremes after reset, then arrays covering every leftover count.
  stim_row_t dir_rows [22] = '{
    '{8'h00, 1'b1, 2'd2, "00"},
    '{8'hFF, 1'b1, 2'd2, "z7"},
    '{8'h1F, 1'b1, 2'd2, "z0"},
    '{8'hE0, 1'b1, 2'd2, "07"},
    '{8'hFF, 1'b0, 2'd0, 24'h0},
    '{8'h00, 1'b0, 2'd0, 24'h0},
    '{8'hAA, 1'b0, 2'd0, 24'h0},
    '{8'h55, 1'b0, 2'd0, 24'h0},
    '{8'h81, 1'b1, 2'd0, 24'h0},
    '{8'h5A, 1'b0, 2'd0, 24'h0},
    '{8'hC3, 1'b1, 2'd0, 24'h0},
    '{8'h01, 1'b0, 2'd0, 24'h0},
    '{8'h80, 1'b0, 2'd0, 24'h0},
    '{8'h7E, 1'b1, 2'd0, 24'h0},
    '{8'h33, 1'b0, 2'd0, 24'h0},
    '{8'hCC, 1'b0, 2'd0, 24'h0},
    '{8'hF0, 1'b0, 2'd0, 24'h0},
    '{8'h0F, 1'b1, 2'd0, 24'h0},
    '{8'hA5, 1'b0, 2'd0, 24'h0},
    '{8'h3C, 1'b0, 2'd0, 24'h0},
    '{8'h96, 1'b0, 2'd0, 24'h0},
    '{8'h69, 1'b1, 2'd0, 24'h0}
  };

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Symbols for one byte; updates the leftover bits.
  function automatic int encode_byte(input logic [7:0] d, input logic f, output sym_t syms [3]);
    logic [11:0] acc;
    int          total;
    int          n;
    acc   = {8'h00, left_bits} | ({4'h0, d} << left_count);
    total = int'(left_count) + 8;
    n     = 0;
    while (total >= 5) begin
      syms[n].ch   = 7'(b32_alphabet[acc[4:0]]);
      syms[n].last = 1'b0;
      n++;
      acc   = acc >> 5;
      total = total - 5;
    end
    if (f) begin
      syms[n].ch   = 7'(b32_alphabet[acc[4:0]]);
      syms[n].last = 1'b1;
      n++;
      left_bits  = 4'h0;
      left_count = 3'd0;
    end else begin
      left_bits  = acc[3:0];
      left_count = total[2:0];
    end
    return n;
  endfunction

  // Offers one byte item, honoring bursts and gaps, and records its symbols.
  task automatic feed_byte(input logic [7:0] d, input logic f, input logic [1:0] typed_n,
                           input logic [23:0] typed_chars);
    sym_t pred [3];
    sym_t typed_sym;
    int   n;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_ch.valid      = 1'b1;
    in_ch.data_byte  = d;
    in_ch.final_byte = f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = encode_byte(d, f, pred);
    if (typed_n != 2'd0) begin
      for (int i = 0; i < int'(typed_n); i++) begin
        typed_sym.ch   = typed_chars[8*(int'(typed_n)-1-i) +: 7];
        typed_sym.last = (i == int'(typed_n) - 1);
        symbols_due.push_back(typed_sym);
      end
    end else begin
      for (int i = 0; i < n; i++) symbols_due.push_back(pred[i]);
    end
    burst_left--;
    bytes_fed++;
    @(negedge clk);
  endtask

  // Receiver stalls: the mode is redrawn whenever the phase counter runs out.
  always @(negedge clk) begin
    if (ready_phase == 0) begin
      ready_mode  <= $urandom_range(0, 2);
      ready_phase <= 50;
    end else begin
      ready_phase <= ready_phase - 1;
    end
    if (stall_run > 0) begin
      stall_run    <= stall_run - 1;
      out_ch.ready <= 1'b0;
    end else if (ready_mode == 1) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else if (ready_mode == 2 && $urandom_range(0, 1) == 0) begin
      stall_run    <= $urandom_range(0, 5);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Symbol checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (symbols_due.size() == 0) begin
        $display("%0t: unexpected symbol, actual char=%02h last=%b", $time,
                 out_ch.symbol_char, out_ch.last_symbol);
        errors++;
      end else begin
        due_sym = symbols_due.pop_front();
        if (out_ch.symbol_char !== due_sym.ch || out_ch.last_symbol !== due_sym.last) begin
          $display("%0t: symbol mismatch, expected char=%02h last=%b, actual char=%02h last=%b",
                   $time, due_sym.ch, due_sym.last, out_ch.symbol_char, out_ch.last_symbol);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout with %0d symbols outstanding", $time, symbols_due.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin
    int arr_len;
    logic [7:0] d;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.final_byte = 1'b0;
    left_bits        = 4'h0;
    left_count       = 3'd0;
    bytes_fed        = 0;
    burst_left       = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed rows.
    foreach (dir_rows[i]) begin
      feed_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].nexp, dir_rows[i].chars);
    end

    // Random arrays, mostly short, a few long.
    while (bytes_fed < NUM_ITEMS) begin
      arr_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
      for (int i = 0; i < arr_len; i++) begin
        if ($urandom_range(0, 7) == 0) d = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        else d = 8'($urandom_range(0, 255));
        feed_byte(d, i == arr_len - 1, 2'd0, 24'h0);
      end
    end
    in_ch.valid = 1'b0;

    // Drain, then allow the pipeline to settle.
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/b32e_pkg.sv
rtl/b32e_chan_if.sv
rtl/b32e_front.sv
rtl/b32e_queue.sv
rtl/b32e_back.sv
rtl/base32_lsb_first_encoder.sv
test/tb_base32_lsb_first_encoder.sv
